// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCI_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define PCI_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCI_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// File: rtl/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg
// Shared types, register indexes and palette ROM of the color interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

  localparam int SampleBitsDef   = 16;
  localparam int BlendFracDef    = 8;
  // Normalized value is unsigned 16 bits, all ones meaning 1.0
  localparam int NormBits        = 16;
  localparam int NormOne         = 65535;
  localparam int DivBitsPerStage = 2;
  localparam int PalCount        = 8;
  localparam int PalMax          = 17;

  typedef enum logic [1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_RANGE_HIGH  = 2'd1,
    REG_PALETTE_SEL = 2'd2
  } reg_idx_e;

  // Saturation flags that ride along the divider
  typedef struct packed {
    logic clamp_lo;
    logic clamp_hi;
  } clamp_t;

  // {red, green, blue}
  typedef logic [23:0] rgb_t;

  // Last valid entry per palette (length minus one)
  localparam logic [4:0] PAL_LAST [PalCount] = '{
    5'd10, 5'd9, 5'd10, 5'd10, 5'd16, 5'd10, 5'd9, 5'd4
  };

  localparam rgb_t PAL_ROM [PalCount][PalMax] = '{
    // viridis
    '{ {8'd68,8'd1,8'd84}, {8'd72,8'd35,8'd116}, {8'd64,8'd67,8'd135},
       {8'd52,8'd94,8'd141}, {8'd41,8'd120,8'd142}, {8'd32,8'd144,8'd140},
       {8'd34,8'd167,8'd132}, {8'd68,8'd190,8'd112}, {8'd121,8'd209,8'd81},
       {8'd189,8'd222,8'd38}, {8'd253,8'd231,8'd36},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0 },
    // plasma
    '{ {8'd12,8'd7,8'd134}, {8'd82,8'd3,8'd252}, {8'd135,8'd31,8'd251},
       {8'd178,8'd59,8'd232}, {8'd212,8'd91,8'd200}, {8'd237,8'd121,8'd162},
       {8'd252,8'd152,8'd122}, {8'd254,8'd187,8'd90}, {8'd246,8'd222,8'd73},
       {8'd239,8'd248,8'd33},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0 },
    // inferno
    '{ {8'd0,8'd0,8'd3}, {8'd20,8'd14,8'd54}, {8'd58,8'd25,8'd94},
       {8'd95,8'd38,8'd116}, {8'd133,8'd51,8'd124}, {8'd170,8'd63,8'd122},
       {8'd206,8'd78,8'd113}, {8'd237,8'd105,8'd93}, {8'd251,8'd155,8'd74},
       {8'd252,8'd206,8'd37}, {8'd252,8'd255,8'd164},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0 },
    // magma
    '{ {8'd0,8'd0,8'd3}, {8'd20,8'd13,8'd53}, {8'd54,8'd24,8'd89},
       {8'd91,8'd36,8'd115}, {8'd127,8'd49,8'd127}, {8'd164,8'd63,8'd130},
       {8'd201,8'd79,8'd126}, {8'd234,8'd107,8'd114}, {8'd253,8'd155,8'd104},
       {8'd254,8'd205,8'd141}, {8'd252,8'd253,8'd191},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0 },
    // turbo
    '{ {8'd59,8'd76,8'd192}, {8'd68,8'd90,8'd204}, {8'd77,8'd104,8'd215},
       {8'd87,8'd117,8'd225}, {8'd98,8'd130,8'd234}, {8'd108,8'd142,8'd241},
       {8'd119,8'd154,8'd247}, {8'd130,8'd165,8'd251}, {8'd141,8'd176,8'd254},
       {8'd152,8'd185,8'd255}, {8'd163,8'd194,8'd255}, {8'd174,8'd201,8'd253},
       {8'd184,8'd208,8'd249}, {8'd194,8'd213,8'd244}, {8'd204,8'd217,8'd238},
       {8'd213,8'd219,8'd230}, {8'd221,8'd221,8'd221} },
    // redblue
    '{ {8'd5,8'd48,8'd97}, {8'd33,8'd102,8'd172}, {8'd67,8'd147,8'd195},
       {8'd146,8'd197,8'd222}, {8'd209,8'd229,8'd240}, {8'd247,8'd247,8'd247},
       {8'd253,8'd219,8'd199}, {8'd244,8'd165,8'd130}, {8'd214,8'd96,8'd77},
       {8'd178,8'd24,8'd43}, {8'd103,8'd0,8'd31},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0 },
    // greenred
    '{ {8'd0,8'd104,8'd55}, {8'd26,8'd152,8'd80}, {8'd102,8'd189,8'd99},
       {8'd166,8'd217,8'd106}, {8'd217,8'd239,8'd139}, {8'd254,8'd224,8'd139},
       {8'd253,8'd174,8'd97}, {8'd244,8'd109,8'd67}, {8'd215,8'd48,8'd39},
       {8'd165,8'd0,8'd38},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0 },
    // five-color
    '{ {8'd0,8'd0,8'd255}, {8'd0,8'd255,8'd255}, {8'd0,8'd255,8'd0},
       {8'd255,8'd255,8'd0}, {8'd255,8'd0,8'd0},
       24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
       24'h0, 24'h0 }
  };

endpackage

`default_nettype wire

// File: rtl/pci_front.sv
// ----------------------------------------------------------------------------
// pci_front
// Range subtraction, orientation fix, saturation flags and divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_front #(
  parameter int SAMPLE_BITS = pci_pkg::SampleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          valid_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] range_low_i,
  input  wire logic signed [SAMPLE_BITS-1:0] range_high_i,
  output logic                               valid_o,
  output pci_pkg::clamp_t                    clamp_o,
  output logic [SAMPLE_BITS-1:0]             den_o,
  output logic [SAMPLE_BITS-1:0]             rem_o,
  output logic [pci_pkg::NormBits-1:0]       low_o
);

  localparam int NB = pci_pkg::NormBits;
  localparam int DW = SAMPLE_BITS + NB;

  logic signed [SAMPLE_BITS:0] num_s, den_s, num_f, den_f;
  logic [SAMPLE_BITS-1:0]      num_u, den_u;
  logic [DW-1:0]               dividend;
  pci_pkg::clamp_t             clamp_d;

  logic                        valid_q;
  pci_pkg::clamp_t             clamp_q;
  logic [SAMPLE_BITS-1:0]      den_q, rem_q;
  logic [NB-1:0]               low_q;

  // Differences, flipped so the divisor is not negative
  always_comb begin
    num_s = {sample_i[SAMPLE_BITS-1], sample_i} - {range_low_i[SAMPLE_BITS-1], range_low_i};
    den_s = {range_high_i[SAMPLE_BITS-1], range_high_i}
          - {range_low_i[SAMPLE_BITS-1], range_low_i};
    num_f = den_s[SAMPLE_BITS] ? -num_s : num_s;
    den_f = den_s[SAMPLE_BITS] ? -den_s : den_s;
    clamp_d.clamp_lo = (den_s == '0) || (num_f <= 0);
    clamp_d.clamp_hi = !clamp_d.clamp_lo && (num_f >= den_f);
    num_u = num_f[SAMPLE_BITS-1:0];
    den_u = den_f[SAMPLE_BITS-1:0];
    // num * 65535 as (num << 16) - num
    dividend = {num_u, {NB{1'b0}}} - DW'(num_u);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      clamp_q <= clamp_d;
      den_q   <= den_u;
      rem_q   <= dividend[DW-1:NB];
      low_q   <= dividend[NB-1:0];
    end
  end

  assign valid_o = valid_q;
  assign clamp_o = clamp_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;

endmodule

`default_nettype wire

// File: rtl/pci_divider.sv
// ----------------------------------------------------------------------------
// pci_divider
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pci_divider #(
  parameter int SAMPLE_BITS = pci_pkg::SampleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          valid_i,
  input  wire pci_pkg::clamp_t               clamp_i,
  input  wire logic [SAMPLE_BITS-1:0]        den_i,
  input  wire logic [SAMPLE_BITS-1:0]        rem_i,
  input  wire logic [pci_pkg::NormBits-1:0]  low_i,
  output logic                               valid_o,
  output pci_pkg::clamp_t                    clamp_o,
  output logic [pci_pkg::NormBits-1:0]       quot_o
);

  localparam int NB = pci_pkg::NormBits;
  localparam int BPS = pci_pkg::DivBitsPerStage;
  localparam int NS = NB / BPS;

  // Index 0 is the stage input; index g+1 is register stage g
  logic                   v_q   [NS+1];
  pci_pkg::clamp_t        c_q   [NS+1];
  logic [SAMPLE_BITS-1:0] den_q [NS+1];
  logic [SAMPLE_BITS-1:0] rem_q [NS+1];
  // Remaining dividend bits leave at the top, quotient bits enter at the bottom
  logic [NB-1:0]          sh_q  [NS+1];

  assign v_q[0]   = valid_i;
  assign c_q[0]   = clamp_i;
  assign den_q[0] = den_i;
  assign rem_q[0] = rem_i;
  assign sh_q[0]  = low_i;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [SAMPLE_BITS-1:0] rem_d;
    logic [NB-1:0]          sh_d;

    // BPS trial subtractions
    always_comb begin
      logic [SAMPLE_BITS:0] trial;
      logic                 qbit;
      rem_d = rem_q[g];
      sh_d  = sh_q[g];
      for (int k = 0; k < BPS; k++) begin
        trial = {rem_d, sh_d[NB-1]};
        qbit  = (trial >= {1'b0, den_q[g]});
        if (qbit) begin
          trial = trial - {1'b0, den_q[g]};
        end
        rem_d = trial[SAMPLE_BITS-1:0];
        sh_d  = {sh_d[NB-2:0], qbit};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        c_q[g+1]   <= c_q[g];
        den_q[g+1] <= den_q[g];
        rem_q[g+1] <= rem_d;
        sh_q[g+1]  <= sh_d;
      end
    end
  end

  assign valid_o = v_q[NS];
  assign clamp_o = c_q[NS];
  assign quot_o  = sh_q[NS];

  // Unsaturated items always leave a remainder below the divisor
  `PCI_ASSERT(a_rem_below_den, clk_i, rst_ni, v_q[NS] && !c_q[NS].clamp_lo && !c_q[NS].clamp_hi |-> rem_q[NS] < den_q[NS], "divider remainder not below divisor")
  // Both saturation flags never set at once
  `PCI_ASSERT_NEVER(a_clamp_excl, clk_i, rst_ni, v_q[NS] && c_q[NS].clamp_lo && c_q[NS].clamp_hi, "both clamp flags set")

endmodule

`default_nettype wire

// File: rtl/pci_blend.sv
// ----------------------------------------------------------------------------
// pci_blend
// Palette scaling, index/fraction split, ROM lookup and linear blend.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pci_blend #(
  parameter int BLEND_FRACTION_BITS = pci_pkg::BlendFracDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          valid_i,
  input  wire pci_pkg::clamp_t               clamp_i,
  input  wire logic [pci_pkg::NormBits-1:0]  quot_i,
  input  wire logic [2:0]                    pal_sel_i,
  output logic                               valid_o,
  output pci_pkg::rgb_t                      rgb_o
);

  localparam int NB = pci_pkg::NormBits;
  localparam int BF = BLEND_FRACTION_BITS;
  localparam int PW = NB + 5;
  localparam int SW = 8 + BF + 2;
  localparam logic [NB:0] ONE_N = (NB+1)'(pci_pkg::NormOne);

  // Scale stage
  logic [NB-1:0] norm;
  logic          p_valid_q;
  logic [PW-1:0] pos_q;
  logic [2:0]    p_sel_q;

  always_comb begin
    if (clamp_i.clamp_lo) begin
      norm = '0;
    end else if (clamp_i.clamp_hi) begin
      norm = '1;
    end else begin
      norm = quot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (adv_i) begin
      p_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pos_q   <= PW'(norm) * PW'(pci_pkg::PAL_LAST[pal_sel_i]);
      p_sel_q <= pal_sel_i;
    end
  end

  // Index stage: pos / 65535 with one correction
  logic [NB:0]   psum;
  logic [4:0]    idx_d;
  logic [NB-1:0] prem_d;
  logic          i_valid_q;
  logic [4:0]    idx_q;
  logic [NB-1:0] rem_q;
  logic [2:0]    i_sel_q;

  always_comb begin
    psum = (NB+1)'(pos_q[PW-1:NB]) + (NB+1)'(pos_q[NB-1:0]);
    if (psum >= ONE_N) begin
      idx_d  = pos_q[PW-1:NB] + 5'd1;
      prem_d = NB'(psum - ONE_N);
    end else begin
      idx_d  = pos_q[PW-1:NB];
      prem_d = psum[NB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_valid_q <= 1'b0;
    end else if (adv_i) begin
      i_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q   <= idx_d;
      rem_q   <= prem_d;
      i_sel_q <= p_sel_q;
    end
  end

  // Fraction and ROM stage
  logic [NB+BF-1:0] fx;
  logic [NB:0]      fsum;
  logic [BF-1:0]    frac_d;
  logic [4:0]       last, up_idx;
  logic             f_valid_q;
  logic [BF-1:0]    frac_q;
  pci_pkg::rgb_t    lo_q, hi_q;

  always_comb begin
    fx   = {rem_q, {BF{1'b0}}};
    fsum = (NB+1)'(fx[NB+BF-1:NB]) + (NB+1)'(fx[NB-1:0]);
    frac_d = (fsum >= ONE_N) ? fx[NB+BF-1:NB] + BF'(1) : fx[NB+BF-1:NB];
    last   = pci_pkg::PAL_LAST[i_sel_q];
    up_idx = (idx_q < last) ? idx_q + 5'd1 : last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv_i) begin
      f_valid_q <= i_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      frac_q <= frac_d;
      lo_q   <= pci_pkg::PAL_ROM[i_sel_q][idx_q];
      hi_q   <= pci_pkg::PAL_ROM[i_sel_q][up_idx];
    end
  end

  // Blend stage, rounded to nearest, into the output register
  pci_pkg::rgb_t rgb_d;
  logic          o_valid_q;
  pci_pkg::rgb_t rgb_q;

  always_comb begin
    logic [SW-1:0] sum;
    logic [SW-1:0] onem;
    onem = (SW'(1) << BF) - SW'(frac_q);
    for (int c = 0; c < 3; c++) begin
      sum = SW'(lo_q[c*8 +: 8]) * onem + SW'(hi_q[c*8 +: 8]) * SW'(frac_q)
          + (SW'(1) << (BF - 1));
      rgb_d[c*8 +: 8] = sum[BF +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (adv_i) begin
      o_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = o_valid_q;
  assign rgb_o   = rgb_q;

  // Index never runs past the selected palette
  `PCI_ASSERT(a_idx_in_pal, clk_i, rst_ni, i_valid_q |-> idx_q <= pci_pkg::PAL_LAST[i_sel_q], "palette index out of range")

endmodule

`default_nettype wire

// File: rtl/palette_color_interpolator.sv
// ----------------------------------------------------------------------------
// palette_color_interpolator
// False-color mapper: signed sample to interpolated RGB from a palette ROM.
// ----------------------------------------------------------------------------
// Takes one sample per clock and returns one color per sample, in order.
// An accepted request passes, in order, through the range subtraction
// register, the pipelined divider (two quotient bits per stage) that
// normalizes the sample, the palette scaling, index/fraction split and ROM
// lookup registers, and the blend into the output register. The whole
// pipeline holds while a result waits on m_axis_tready, so s_axis_tready
// follows that stall. Write the range and palette registers only while no
// request is in flight.
`default_nettype none
`include "assert_macros.svh"

module palette_color_interpolator #(
  parameter int SAMPLE_BITS         = pci_pkg::SampleBitsDef,
  parameter int BLEND_FRACTION_BITS = pci_pkg::BlendFracDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [SAMPLE_BITS-1:0]              cfg_data_i,
  // Sample stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample
  // Color stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [23:0]                              m_axis_tdata   // red, green, blue
);

  localparam int NB = pci_pkg::NormBits;
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST = SAMPLE_BITS'(32767);

  logic signed [SAMPLE_BITS-1:0] range_low_q, range_high_q;
  logic [2:0]                    pal_sel_q;
  logic                          adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= HIGH_RST;
      pal_sel_q    <= '0;
    end else if (cfg_we_i) begin
      case (pci_pkg::reg_idx_e'(cfg_index_i))
        pci_pkg::REG_RANGE_LOW:   range_low_q  <= cfg_data_i;
        pci_pkg::REG_RANGE_HIGH:  range_high_q <= cfg_data_i;
        pci_pkg::REG_PALETTE_SEL: pal_sel_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless a result is held
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic                   f_valid;
  pci_pkg::clamp_t        f_clamp;
  logic [SAMPLE_BITS-1:0] f_den, f_rem;
  logic [NB-1:0]          f_low;

  pci_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (s_axis_tvalid),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .range_low_i (range_low_q),
    .range_high_i(range_high_q),
    .valid_o     (f_valid),
    .clamp_o     (f_clamp),
    .den_o       (f_den),
    .rem_o       (f_rem),
    .low_o       (f_low)
  );

  logic            d_valid;
  pci_pkg::clamp_t d_clamp;
  logic [NB-1:0]   d_quot;

  pci_divider #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(f_valid),
    .clamp_i(f_clamp),
    .den_i  (f_den),
    .rem_i  (f_rem),
    .low_i  (f_low),
    .valid_o(d_valid),
    .clamp_o(d_clamp),
    .quot_o (d_quot)
  );

  pci_pkg::rgb_t rgb;

  pci_blend #(
    .BLEND_FRACTION_BITS(BLEND_FRACTION_BITS)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (d_valid),
    .clamp_i  (d_clamp),
    .quot_i   (d_quot),
    .pal_sel_i(pal_sel_q),
    .valid_o  (m_axis_tvalid),
    .rgb_o    (rgb)
  );

  // red in the low byte
  assign m_axis_tdata = {rgb[7:0], rgb[15:8], rgb[23:16]};

  // A held result blocks new requests
  `PCI_ASSERT(a_stall_blocks_in, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "request taken while output stalled")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: palette color interpolator testbench
// Drives signed samples through the false-color mapper under several range
// and palette settings, predicts or lists each expected color and checks every result.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] RegUnused = 2'd3;  // index with no register behind it
  localparam int PipeDepth = 16;            // deeper than the pipeline
  localparam int IdleLimit = 4000;

  // Output word, red in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct {
    bit          is_write;
    logic [1:0]  index;
    logic [15:0] value;
    bit          typed;
    color_t      want;
  } step_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;   // sample
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;   // red, green, blue

  palette_color_interpolator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Predictor copy of the registers
  logic signed [15:0] cur_low, cur_high;
  logic [2:0]         cur_pal;

  color_t color_q[$];
  step_t  plan[$];
  int     errors, samples_sent, colors_seen, burst_left, idle_cycles, cycle_cnt;
  bit     stim_done;

  function automatic color_t mk_color(int r, int g, int b);
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  // Normalize, scale to the palette, split index/fraction and blend
  function automatic color_t map_sample(logic signed [15:0] smp);
    longint num, den, norm, pos, idx, up, frac, last;
    pci_pkg::rgb_t c0, c1;
    logic [7:0] ch [3];
    num  = longint'(smp) - longint'(cur_low);
    den  = longint'(cur_high) - longint'(cur_low);
    last = pci_pkg::PAL_LAST[cur_pal];
    if (den == 0) begin
      c0 = pci_pkg::PAL_ROM[cur_pal][0];
      return {c0[7:0], c0[15:8], c0[23:16]};
    end
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) norm = 0;
    else if (num >= den) norm = pci_pkg::NormOne;
    else norm = (num * pci_pkg::NormOne) / den;
    pos  = norm * last;
    idx  = pos / pci_pkg::NormOne;
    frac = ((pos % pci_pkg::NormOne) << 8) / pci_pkg::NormOne;
    if (idx > last) idx = last;
    up = (idx + 1 <= last) ? idx + 1 : last;
    c0 = pci_pkg::PAL_ROM[cur_pal][idx];
    c1 = pci_pkg::PAL_ROM[cur_pal][up];
    for (int k = 0; k < 3; k++)
      ch[k] = 8'((longint'(c0[23-8*k -: 8]) * (256 - frac)
                 + longint'(c1[23-8*k -: 8]) * frac + 128) >> 8);
    return {ch[2], ch[1], ch[0]};
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Drain the pipeline so registers can be written safely
  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (index)
      pci_pkg::REG_RANGE_LOW:   cur_low  = value;
      pci_pkg::REG_RANGE_HIGH:  cur_high = value;
      pci_pkg::REG_PALETTE_SEL: cur_pal  = value[2:0];
      default: ;
    endcase
  endtask

  // One request; bursts of random length separated by short gaps
  task automatic send_sample(logic [15:0] smp, bit typed, color_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    color_q.insert(color_q.size(), typed ? want : map_sample(smp));
    samples_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic add_write(logic [1:0] index, int value);
    plan.insert(plan.size(), '{1'b1, index, 16'(value), 1'b0, '0});
  endtask

  task automatic add_sample(int value, bit typed = 0, color_t want = '0);
    plan.insert(plan.size(), '{1'b0, 2'd0, 16'(value), typed, want});
  endtask

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    color_t got, want;
    got = m_axis_tdata;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      colors_seen++;
      if (color_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected color %h, nothing pending", $time, got);
      end else begin
        want = color_q.pop_front();
        if (got.red !== want.red) begin
          errors++;
          $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
        end
        if (got.green !== want.green) begin
          errors++;
          $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
        end
        if (got.blue !== want.blue) begin
          errors++;
          $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
        end
      end
    end
  end

  // Receiver stall pattern: free, light, heavy, then periodic
  always @(posedge clk_i) begin
    cycle_cnt++;
    case ((cycle_cnt / 256) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(3) != 0);
      2: m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= ((cycle_cnt % 6) < 3);
    endcase
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IdleLimit) begin
      $display("%0t: no progress, %0d colors pending", $time, color_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int mn, mx, v, sel;
    logic signed [15:0] lo, hi;
    cfg_we_i = 1'b0;
    cfg_index_i = pci_pkg::REG_RANGE_LOW;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    errors = 0; samples_sent = 0; colors_seen = 0;
    burst_left = 0; idle_cycles = 0; cycle_cnt = 0;
    cur_low = 16'sd0; cur_high = 16'sd32767; cur_pal = 3'd0;

    // Directed: reset values, ends of the range, equal and inverted bounds
    add_sample(0, 1, mk_color(68, 1, 84));
    add_sample(32767, 1, mk_color(253, 231, 36));
    add_sample(-32768, 1, mk_color(68, 1, 84));
    add_sample(16384);
    add_write(pci_pkg::REG_PALETTE_SEL, 7);
    add_write(pci_pkg::REG_RANGE_LOW, -100);
    add_write(pci_pkg::REG_RANGE_HIGH, 100);
    add_sample(0);
    add_sample(50);
    add_sample(100, 1, mk_color(255, 0, 0));
    add_sample(-101, 1, mk_color(0, 0, 255));
    add_write(pci_pkg::REG_RANGE_LOW, 5);
    add_write(pci_pkg::REG_RANGE_HIGH, 5);
    add_sample(5, 1, mk_color(0, 0, 255));
    add_sample(-32768, 1, mk_color(0, 0, 255));
    add_write(pci_pkg::REG_RANGE_LOW, 100);
    add_write(pci_pkg::REG_RANGE_HIGH, -100);
    add_sample(100, 1, mk_color(0, 0, 255));
    add_sample(-100, 1, mk_color(255, 0, 0));
    add_sample(32767, 1, mk_color(0, 0, 255));
    add_sample(-32768, 1, mk_color(255, 0, 0));
    add_sample(0);
    add_write(pci_pkg::REG_PALETTE_SEL, 4);
    add_write(pci_pkg::REG_RANGE_LOW, -32768);
    add_write(pci_pkg::REG_RANGE_HIGH, 32767);
    add_sample(-32768, 1, mk_color(59, 76, 192));
    add_sample(32767, 1, mk_color(221, 221, 221));
    add_sample(0);
    add_sample(1);
    // Write to an unused index must change nothing
    add_write(RegUnused, 1234);
    add_sample(0);
    add_sample(-1);

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        go_idle();
        write_reg(plan[i].index, plan[i].value);
      end else begin
        send_sample(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, every palette, extreme and degenerate ranges
    for (int ph = 0; ph < 16; ph++) begin
      sel = $urandom_range(9);
      case (sel)
        0: begin lo = 16'sh8000; hi = 16'sd32767; end
        1: begin lo = 16'sd32767; hi = 16'sh8000; end
        2: begin lo = 16'($urandom); hi = lo; end
        3: begin
          lo = 16'($urandom_range(0, 65530) - 32768);
          hi = lo + 16'($urandom_range(1, 5));
        end
        default: begin lo = 16'($urandom); hi = 16'($urandom); end
      endcase
      go_idle();
      write_reg(pci_pkg::REG_RANGE_LOW, lo);
      write_reg(pci_pkg::REG_RANGE_HIGH, hi);
      write_reg(pci_pkg::REG_PALETTE_SEL, 16'(ph % 8));
      mn = (lo < hi) ? lo : hi;
      mx = (lo < hi) ? hi : lo;
      for (int n = 0; n < 96; n++) begin
        sel = $urandom_range(9);
        if (sel < 6) begin
          v = mn + int'($urandom_range(mx - mn));
        end else if (sel < 8) begin
          v = ((sel == 6) ? mn : mx) + int'($urandom_range(4)) - 2;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end else begin
          v = int'($urandom);
        end
        send_sample(16'(v), 0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth * 2) @(posedge clk_i);
    $display("Mapped %0d samples to %0d colors over 16 random range/palette phases",
             samples_sent, colors_seen);
    $display("plus directed clamp, equal-bound and inverted-range cases; %0d errors",
             errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
